### rtl/spd_pkg.sv
// Shared types and constants for the stereo peak decimator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CFG_W       = 13;
	localparam int COUNT_W     = 12;
	localparam int INDEX_W     = 32;
	localparam int MAX_GROUP   = 4096;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SAMPLE_BITS-1:0]        level_t;
	typedef logic [CFG_W-1:0]              group_size_t;
	typedef logic [COUNT_W-1:0]            pair_count_t;
	typedef logic [INDEX_W-1:0]            point_index_t;

	// Start values of the peak trackers: most negative and most positive code
	localparam sample_t POS_PEAK_START = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam sample_t NEG_PEAK_START = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	localparam group_size_t GROUP_MIN = group_size_t'(1);
	localparam group_size_t GROUP_MAX = group_size_t'(MAX_GROUP);

	// Control from the group counter to each channel lane
	typedef struct packed {
		logic take;   // a word is accepted this cycle
		logic first;  // it is the first pair of a group
		logic clear;  // the group ends or is dropped after it
	} spd_lane_ctl_t;

	// Peak v mapped to v + 2^(SAMPLE_BITS-1): flip the sign bit
	function automatic level_t to_level(input sample_t v);
		return {~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
	endfunction

endpackage

### rtl/spd_lane.sv
// One channel lane: positive and non-positive peak tracking for a group.
// Depends on spd_pkg.
`timescale 1ns / 1ps

module spd_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spd_pkg::spd_lane_ctl_t ctl,
	input  spd_pkg::sample_t       sample,
	output spd_pkg::level_t        level
);

	spd_pkg::sample_t pos_peak_q;
	spd_pkg::sample_t neg_peak_q;
	logic             first_pos_q;

	spd_pkg::sample_t pos_peak_d;
	spd_pkg::sample_t neg_peak_d;
	spd_pkg::sample_t chosen;
	logic             first_pos_d;
	logic             is_pos;

	// Update peaks with the incoming sample and pick the one to report
	always_comb begin
		is_pos      = !sample[spd_pkg::SAMPLE_BITS-1] && (sample != '0);
		first_pos_d = ctl.first ? is_pos : first_pos_q;
		pos_peak_d  = (is_pos && (sample > pos_peak_q)) ? sample : pos_peak_q;
		neg_peak_d  = (!is_pos && (sample < neg_peak_q)) ? sample : neg_peak_q;
		chosen      = first_pos_d ? pos_peak_d : neg_peak_d;
		level       = spd_pkg::to_level(chosen);
	end

	// Peak state; restarts after a group ends or is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_peak_q  <= spd_pkg::POS_PEAK_START;
			neg_peak_q  <= spd_pkg::NEG_PEAK_START;
			first_pos_q <= 1'b0;
		end else if (ctl.take) begin
			if (ctl.clear) begin
				pos_peak_q  <= spd_pkg::POS_PEAK_START;
				neg_peak_q  <= spd_pkg::NEG_PEAK_START;
				first_pos_q <= 1'b0;
			end else begin
				pos_peak_q  <= pos_peak_d;
				neg_peak_q  <= neg_peak_d;
				first_pos_q <= first_pos_d;
			end
		end
	end

endmodule

### rtl/spd_out_reg.sv
// Merge stage: joins the lane levels and the point index into one output word.
// Depends on spd_pkg.
`timescale 1ns / 1ps

module spd_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  spd_pkg::point_index_t point_index,
	input  spd_pkg::level_t       left_level,
	input  spd_pkg::level_t       right_level,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata
);

	logic        valid_q;
	logic [63:0] data_q;

	// Valid flag: set on load, cleared when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload: index low, left then right above it
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {right_level, left_level, point_index};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

### rtl/stereo_peak_decimator_unit.sv
// Top level of the stereo peak decimator: group counter, two channel lanes,
// output register. Depends on spd_pkg, spd_lane and spd_out_reg.
`timescale 1ns / 1ps

//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: left_sample, right_sample; s_tlast: end_of_buffer
//  m_*      | out | m_tvalid/m_tready  | m_tdata: point_index, left_level, right_level
//  cfg_*    | in  | cfg_we             | cfg_wdata: pairs_per_point
//
// One pair is taken per cycle while the input is not stalled; a point leaves in the cycle
// after the pair that closes its group. Both lanes update in the same cycle as the accept.
// The input stalls only when a pair would close a group while the output
// register still holds an untaken word. Reset sets group size to 1, clears the
// counter and the point index, and sets the peaks to their start values.

module stereo_peak_decimator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] left_sample, [31:16] right_sample
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] point_index, [47:32] left_level,
	                               // [63:48] right_level
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata  // pairs_per_point
);

	spd_pkg::group_size_t   group_size_q;
	spd_pkg::pair_count_t   pair_count_q;
	spd_pkg::point_index_t  point_index_q;

	spd_pkg::group_size_t   size_eff;
	spd_pkg::spd_lane_ctl_t lane_ctl;
	spd_pkg::level_t        left_level;
	spd_pkg::level_t        right_level;
	logic                   take;
	logic                   group_done;

	// Group size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= spd_pkg::GROUP_MIN;
		end else if (cfg_we) begin
			group_size_q <= cfg_wdata;
		end
	end

	// Effective size, end of group, handshake
	always_comb begin
		if (group_size_q == '0) begin
			size_eff = spd_pkg::GROUP_MIN;
		end else if (group_size_q > spd_pkg::GROUP_MAX) begin
			size_eff = spd_pkg::GROUP_MAX;
		end else begin
			size_eff = group_size_q;
		end
		group_done     = ({1'b0, pair_count_q} + spd_pkg::group_size_t'(1)) >= size_eff;
		s_tready       = !group_done || !m_tvalid || m_tready;
		take           = s_tvalid && s_tready;
		lane_ctl.take  = take;
		lane_ctl.first = (pair_count_q == '0);
		lane_ctl.clear = group_done || s_tlast;
	end

	// Pair counter and running point index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q  <= '0;
			point_index_q <= '0;
		end else if (take) begin
			if (group_done) begin
				pair_count_q  <= '0;
				point_index_q <= point_index_q + spd_pkg::point_index_t'(1);
			end else if (s_tlast) begin
				pair_count_q  <= '0;
			end else begin
				pair_count_q  <= pair_count_q + spd_pkg::pair_count_t'(1);
			end
		end
	end

	spd_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (s_tdata[15:0]),
		.level  (left_level)
	);

	spd_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (s_tdata[31:16]),
		.level  (right_level)
	);

	spd_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take && group_done),
		.point_index (point_index_q),
		.left_level  (left_level),
		.right_level (right_level),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
